[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the stereo width mixer, empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SWRM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
`define SWRM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define SWRM_ASSERT(lbl, clk, rst_n, prop)
`define SWRM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[hdl/swrm_pkg.sv]
// ----------------------------------------------------------------------------
// swrm_pkg
// Widths, register indexes, word types, sequencer states and saturation
// helpers shared by the stereo width mixer.
// ----------------------------------------------------------------------------
package swrm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 22;

    localparam int MODE_W     = 5;
    localparam int WIDTH_W    = 17;
    localparam int GAIN_W     = 17;
    localparam int TRIG_W     = 18;
    localparam int B0_W       = 23;
    localparam int FB_W       = 48;
    localparam int COEF_W     = 24;
    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int GAIN_FRAC  = 14;
    localparam int TRIG_FRAC  = 16;
    localparam int HP_W       = 32;

    localparam int IN_W    = SAMPLE_BITS + 1;
    localparam int WSIDE_W = IN_W + WIDTH_W - GAIN_FRAC;
    localparam int SIDE_W  = (WSIDE_W > HP_W) ? WSIDE_W : HP_W;
    localparam int LR_W    = ((IN_W > SIDE_W) ? IN_W : SIDE_W) + 1;
    localparam int ROT_W   = LR_W + TRIG_W - TRIG_FRAC + 1;
    localparam int D_W     = HP_W + 3;
    localparam int MUL_A_W = (ROT_W > D_W) ? ROT_W : D_W;
    localparam int MUL_B_W = COEF_W;
    localparam int ACC_W   = MUL_A_W + MUL_B_W + 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LGAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RGAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HP_GAIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HP_FB    = 3'd7;

    // mode flag bits
    localparam int MODE_INV_L = 0;
    localparam int MODE_INV_R = 1;
    localparam int MODE_SWAP  = 2;
    localparam int MODE_MONO  = 3;
    localparam int MODE_BASS  = 4;

    localparam logic [MODE_W-1:0]  RST_MODE    = '0;
    localparam logic [WIDTH_W-1:0] RST_WIDTH   = 17'd16384;
    localparam logic [GAIN_W-1:0]  RST_GAIN    = 17'd16384;
    localparam logic [TRIG_W-1:0]  RST_COS     = 18'd65536;
    localparam logic [TRIG_W-1:0]  RST_SIN     = 18'd0;
    localparam logic [B0_W-1:0]    RST_HP_GAIN = 23'd4194304;
    localparam logic [FB_W-1:0]    RST_HP_FB   = '0;

    typedef logic signed [IN_W-1:0]    t_in_s;
    typedef logic signed [IN_W:0]      t_sum_s;
    typedef logic signed [SIDE_W-1:0]  t_side_s;
    typedef logic signed [LR_W-1:0]    t_lr_s;
    typedef logic signed [D_W-1:0]     t_d_s;
    typedef logic signed [MUL_A_W-1:0] t_mul_a;
    typedef logic signed [MUL_B_W-1:0] t_mul_b;
    typedef logic signed [ACC_W-1:0]   t_acc;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } t_swrm_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_result;
        logic signed [SAMPLE_BITS-1:0] right_result;
    } t_swrm_out;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00_0000_0000_0001,
        ST_WID  = 14'b00_0000_0000_0010,
        ST_SIDE = 14'b00_0000_0000_0100,
        ST_HPD  = 14'b00_0000_0000_1000,
        ST_HA1  = 14'b00_0000_0001_0000,
        ST_HA2  = 14'b00_0000_0010_0000,
        ST_HSAT = 14'b00_0000_0100_0000,
        ST_LC   = 14'b00_0000_1000_0000,
        ST_LS   = 14'b00_0001_0000_0000,
        ST_RS   = 14'b00_0010_0000_0000,
        ST_RC   = 14'b00_0100_0000_0000,
        ST_GL   = 14'b00_1000_0000_0000,
        ST_GR   = 14'b01_0000_0000_0000,
        ST_OUT  = 14'b10_0000_0000_0000
    } t_swrm_state_base;

    typedef t_swrm_state_base t_swrm_state;

    typedef struct packed {
        t_swrm_state state;
        logic        out_step;
        logic        stage;
    } t_swrm_ctl;

    typedef struct packed {
        logic   en;
        logic   clear;
        logic   neg;
        t_mul_a a;
        t_mul_b b;
    } t_swrm_mac_op;

    typedef struct packed {
        logic signed [HP_W-1:0] x1;
        logic signed [HP_W-1:0] x2;
        logic signed [HP_W-1:0] y1;
        logic signed [HP_W-1:0] y2;
    } t_swrm_taps;

    function automatic logic signed [HP_W-1:0] sat_hp(input t_acc v);
        logic [ACC_W-HP_W:0] top;
        top = v[ACC_W-1:HP_W-1];
        if ((&top) || !(|top)) begin
            return v[HP_W-1:0];
        end
        return {v[ACC_W-1], {(HP_W-1){~v[ACC_W-1]}}};
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input t_acc v);
        logic [ACC_W-SAMPLE_BITS:0] top;
        top = v[ACC_W-1:SAMPLE_BITS-1];
        if ((&top) || !(|top)) begin
            return v[SAMPLE_BITS-1:0];
        end
        return {v[ACC_W-1], {(SAMPLE_BITS-1){~v[ACC_W-1]}}};
    endfunction

endpackage

[hdl/swrm_mac.sv]
// ----------------------------------------------------------------------------
// swrm_mac
// Shared signed multiply-accumulate unit: one product per cycle while enabled,
// added to or subtracted from the accumulator, or loaded into it.
// ----------------------------------------------------------------------------
module swrm_mac (
    input  logic                  i_clk,
    input  swrm_pkg::t_swrm_mac_op i_op,
    output swrm_pkg::t_acc        o_acc
);

    logic signed [swrm_pkg::MUL_A_W+swrm_pkg::MUL_B_W-1:0] w_prod;
    swrm_pkg::t_acc w_term;
    swrm_pkg::t_acc w_base;
    swrm_pkg::t_acc r_acc;

    assign w_prod = i_op.a * i_op.b;

    always_comb begin
        w_term = swrm_pkg::t_acc'(w_prod);
        if (i_op.neg) begin
            w_term = -swrm_pkg::t_acc'(w_prod);
        end
        w_base = i_op.clear ? '0 : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= w_base + w_term;
        end
    end

    assign o_acc = r_acc;

endmodule

[hdl/swrm_hpd.sv]
// ----------------------------------------------------------------------------
// swrm_hpd
// Delay words of the two cascaded side-channel highpass biquads.
// ----------------------------------------------------------------------------
module swrm_hpd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_stage,
    input  logic                          i_update,
    input  logic signed [swrm_pkg::HP_W-1:0] i_x,
    input  logic signed [swrm_pkg::HP_W-1:0] i_y,
    output swrm_pkg::t_swrm_taps          o_taps
);

    logic signed [swrm_pkg::HP_W-1:0] r_x1 [2];
    logic signed [swrm_pkg::HP_W-1:0] r_x2 [2];
    logic signed [swrm_pkg::HP_W-1:0] r_y1 [2];
    logic signed [swrm_pkg::HP_W-1:0] r_y2 [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_x1[k] <= '0;
                r_x2[k] <= '0;
                r_y1[k] <= '0;
                r_y2[k] <= '0;
            end
        end else if (i_update) begin
            r_x2[i_stage] <= r_x1[i_stage];
            r_x1[i_stage] <= i_x;
            r_y2[i_stage] <= r_y1[i_stage];
            r_y1[i_stage] <= i_y;
        end
    end

    always_comb begin
        o_taps.x1 = r_x1[i_stage];
        o_taps.x2 = r_x2[i_stage];
        o_taps.y1 = r_y1[i_stage];
        o_taps.y2 = r_y2[i_stage];
    end

endmodule

[hdl/swrm_seq.sv]
// ----------------------------------------------------------------------------
// swrm_seq
// Step sequencer: walks one sample word through the shared MAC schedule.
// ----------------------------------------------------------------------------
module swrm_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_bass,
    input  logic                i_out_load,
    output swrm_pkg::t_swrm_ctl o_ctl
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00_0000_0000_0001,
        S_WID  = 14'b00_0000_0000_0010,
        S_SIDE = 14'b00_0000_0000_0100,
        S_HPD  = 14'b00_0000_0000_1000,
        S_HA1  = 14'b00_0000_0001_0000,
        S_HA2  = 14'b00_0000_0010_0000,
        S_HSAT = 14'b00_0000_0100_0000,
        S_LC   = 14'b00_0000_1000_0000,
        S_LS   = 14'b00_0001_0000_0000,
        S_RS   = 14'b00_0010_0000_0000,
        S_RC   = 14'b00_0100_0000_0000,
        S_GL   = 14'b00_1000_0000_0000,
        S_GR   = 14'b01_0000_0000_0000,
        S_OUT  = 14'b10_0000_0000_0000
    } t_seq_state;

    t_seq_state r_state;
    t_seq_state n_state;
    logic       r_stage;
    logic       n_stage;

    always_comb begin
        n_state = r_state;
        n_stage = r_stage;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_WID;
                end
            end
            S_WID:  n_state = S_SIDE;
            S_SIDE: n_state = i_bass ? S_HPD : S_LC;
            S_HPD:  n_state = S_HA1;
            S_HA1:  n_state = S_HA2;
            S_HA2:  n_state = S_HSAT;
            S_HSAT: begin
                n_stage = ~r_stage;
                n_state = r_stage ? S_LC : S_HPD;
            end
            S_LC:   n_state = S_LS;
            S_LS:   n_state = S_RS;
            S_RS:   n_state = S_RC;
            S_RC:   n_state = S_GL;
            S_GL:   n_state = S_GR;
            S_GR:   n_state = S_OUT;
            S_OUT: begin
                if (i_out_load) begin
                    n_state = i_start ? S_WID : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_stage = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
        end
    end

    always_comb begin
        o_ctl.out_step = (r_state == S_OUT);
        o_ctl.stage    = r_stage;
        case (r_state)
            S_IDLE:  o_ctl.state = swrm_pkg::ST_IDLE;
            S_WID:   o_ctl.state = swrm_pkg::ST_WID;
            S_SIDE:  o_ctl.state = swrm_pkg::ST_SIDE;
            S_HPD:   o_ctl.state = swrm_pkg::ST_HPD;
            S_HA1:   o_ctl.state = swrm_pkg::ST_HA1;
            S_HA2:   o_ctl.state = swrm_pkg::ST_HA2;
            S_HSAT:  o_ctl.state = swrm_pkg::ST_HSAT;
            S_LC:    o_ctl.state = swrm_pkg::ST_LC;
            S_LS:    o_ctl.state = swrm_pkg::ST_LS;
            S_RS:    o_ctl.state = swrm_pkg::ST_RS;
            S_RC:    o_ctl.state = swrm_pkg::ST_RC;
            S_GL:    o_ctl.state = swrm_pkg::ST_GL;
            S_GR:    o_ctl.state = swrm_pkg::ST_GR;
            S_OUT:   o_ctl.state = swrm_pkg::ST_OUT;
            default: o_ctl.state = swrm_pkg::ST_IDLE;
        endcase
    end

endmodule

[hdl/stereo_width_rotation_mixer.sv]
// ----------------------------------------------------------------------------
// stereo_width_rotation_mixer
// Mid/side stereo width, optional mono-bass highpass on the side, rotation,
// balance gains and optional mono fold, on one shared multiply-accumulate.
//
// Input channel: i_in_valid / o_in_stall / i_in_word carry one Q1.23 stereo
// pair per word. Output channel: o_out_valid / i_out_stall / o_out_word carry
// the processed, saturated pair. Configuration: i_cfg_wr_en writes
// i_cfg_wdata into register i_cfg_index on a clock edge; write only while
// idle.
// Each word runs through a fixed MAC schedule, one product per cycle: width,
// then, with mono bass on, two biquads (difference, two feedback terms and a
// saturate step each), then rotation and gains. The next word is taken in the
// cycle the result is loaded; no word is taken while one is in flight.
// The result sits in an output register; while the receiver stalls, one
// more word is computed and waits in the final step, and the input stalls.
// Reset (synchronous, active low) restores the register defaults, clears the
// biquad delays, empties the output register and idles the sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_width_rotation_mixer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  swrm_pkg::t_swrm_in               i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output swrm_pkg::t_swrm_out              o_out_word,
    input  logic                             i_cfg_wr_en,
    input  logic [swrm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [swrm_pkg::CFG_W-1:0]       i_cfg_wdata
);

    // configuration
    logic [swrm_pkg::MODE_W-1:0]  r_mode;
    logic [swrm_pkg::WIDTH_W-1:0] r_width;
    logic [swrm_pkg::GAIN_W-1:0]  r_lgain;
    logic [swrm_pkg::GAIN_W-1:0]  r_rgain;
    logic [swrm_pkg::TRIG_W-1:0]  r_cos;
    logic [swrm_pkg::TRIG_W-1:0]  r_sin;
    logic [swrm_pkg::B0_W-1:0]    r_hp_gain;
    logic [swrm_pkg::FB_W-1:0]    r_hp_fb;

    swrm_pkg::t_swrm_ctl    w_ctl;
    swrm_pkg::t_swrm_mac_op w_op;
    swrm_pkg::t_acc         w_acc;
    swrm_pkg::t_swrm_taps   w_taps;

    logic w_accept;
    logic w_out_load;
    logic w_ready;

    swrm_pkg::t_in_s   w_l;
    swrm_pkg::t_in_s   w_r;
    swrm_pkg::t_in_s   w_la;
    swrm_pkg::t_in_s   w_ra;
    swrm_pkg::t_sum_s  w_sum;
    swrm_pkg::t_sum_s  w_dif;

    logic signed [swrm_pkg::IN_W-1:0]    r_mid;
    swrm_pkg::t_side_s                   r_side;
    logic signed [swrm_pkg::ROT_W-1:0]   r_lr;
    logic signed [swrm_pkg::ROT_W-1:0]   r_rr;
    logic signed [swrm_pkg::SAMPLE_BITS-1:0] r_outl;
    swrm_pkg::t_swrm_out                 r_out_word;
    logic                                r_out_valid;

    swrm_pkg::t_lr_s                     w_lsum;
    swrm_pkg::t_lr_s                     w_rsum;
    logic signed [swrm_pkg::HP_W-1:0]    w_x;
    logic signed [swrm_pkg::HP_W-1:0]    w_y;
    swrm_pkg::t_d_s                      w_d;
    logic signed [swrm_pkg::ROT_W-1:0]   w_rot;
    logic signed [swrm_pkg::SAMPLE_BITS-1:0] w_sat14;
    logic signed [swrm_pkg::SAMPLE_BITS-1:0] w_sat15;
    logic                                w_mono;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= swrm_pkg::RST_MODE;
            r_width   <= swrm_pkg::RST_WIDTH;
            r_lgain   <= swrm_pkg::RST_GAIN;
            r_rgain   <= swrm_pkg::RST_GAIN;
            r_cos     <= swrm_pkg::RST_COS;
            r_sin     <= swrm_pkg::RST_SIN;
            r_hp_gain <= swrm_pkg::RST_HP_GAIN;
            r_hp_fb   <= swrm_pkg::RST_HP_FB;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                swrm_pkg::REG_MODE:    r_mode    <= i_cfg_wdata[swrm_pkg::MODE_W-1:0];
                swrm_pkg::REG_WIDTH:   r_width   <= i_cfg_wdata[swrm_pkg::WIDTH_W-1:0];
                swrm_pkg::REG_LGAIN:   r_lgain   <= i_cfg_wdata[swrm_pkg::GAIN_W-1:0];
                swrm_pkg::REG_RGAIN:   r_rgain   <= i_cfg_wdata[swrm_pkg::GAIN_W-1:0];
                swrm_pkg::REG_COS:     r_cos     <= i_cfg_wdata[swrm_pkg::TRIG_W-1:0];
                swrm_pkg::REG_SIN:     r_sin     <= i_cfg_wdata[swrm_pkg::TRIG_W-1:0];
                swrm_pkg::REG_HP_GAIN: r_hp_gain <= i_cfg_wdata[swrm_pkg::B0_W-1:0];
                swrm_pkg::REG_HP_FB:   r_hp_fb   <= i_cfg_wdata[swrm_pkg::FB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_mono     = r_mode[swrm_pkg::MODE_MONO];
    assign w_out_load = w_ctl.out_step && (!r_out_valid || !i_out_stall);
    assign w_ready    = (w_ctl.state == swrm_pkg::ST_IDLE) || w_out_load;
    assign w_accept   = i_in_valid && w_ready;
    assign o_in_stall = !w_ready;

    swrm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_bass     (r_mode[swrm_pkg::MODE_BASS]),
        .i_out_load (w_out_load),
        .o_ctl      (w_ctl)
    );

    // input conditioning: invert, swap, mid/side
    always_comb begin
        w_l = swrm_pkg::t_in_s'(i_in_word.left_sample);
        w_r = swrm_pkg::t_in_s'(i_in_word.right_sample);
        if (r_mode[swrm_pkg::MODE_INV_L]) begin
            w_l = -w_l;
        end
        if (r_mode[swrm_pkg::MODE_INV_R]) begin
            w_r = -w_r;
        end
        w_la = r_mode[swrm_pkg::MODE_SWAP] ? w_r : w_l;
        w_ra = r_mode[swrm_pkg::MODE_SWAP] ? w_l : w_r;
        w_sum = swrm_pkg::t_sum_s'(w_la) + swrm_pkg::t_sum_s'(w_ra);
        w_dif = swrm_pkg::t_sum_s'(w_la) - swrm_pkg::t_sum_s'(w_ra);
    end

    swrm_hpd u_hpd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (w_ctl.stage),
        .i_update (w_ctl.state == swrm_pkg::ST_HSAT),
        .i_x      (w_x),
        .i_y      (w_y),
        .o_taps   (w_taps)
    );

    always_comb begin
        w_lsum  = swrm_pkg::t_lr_s'(r_mid) + swrm_pkg::t_lr_s'(r_side);
        w_rsum  = swrm_pkg::t_lr_s'(r_mid) - swrm_pkg::t_lr_s'(r_side);
        w_x     = swrm_pkg::sat_hp(swrm_pkg::t_acc'(r_side));
        w_y     = swrm_pkg::sat_hp(w_acc >>> swrm_pkg::COEF_FRAC_BITS);
        w_d     = swrm_pkg::t_d_s'(w_x) - (swrm_pkg::t_d_s'(w_taps.x1) <<< 1)
                + swrm_pkg::t_d_s'(w_taps.x2);
        w_rot   = w_acc[swrm_pkg::TRIG_FRAC +: swrm_pkg::ROT_W];
        w_sat14 = swrm_pkg::sat_out(w_acc >>> swrm_pkg::GAIN_FRAC);
        w_sat15 = swrm_pkg::sat_out(w_acc >>> (swrm_pkg::GAIN_FRAC + 1));
    end

    // MAC schedule
    always_comb begin
        w_op.en    = 1'b1;
        w_op.clear = 1'b1;
        w_op.neg   = 1'b0;
        w_op.a     = '0;
        w_op.b     = '0;
        case (w_ctl.state)
            swrm_pkg::ST_WID: begin
                w_op.a = swrm_pkg::t_mul_a'(r_side);
                w_op.b = swrm_pkg::t_mul_b'(signed'({1'b0, r_width}));
            end
            swrm_pkg::ST_HPD: begin
                w_op.a = swrm_pkg::t_mul_a'(w_d);
                w_op.b = swrm_pkg::t_mul_b'(signed'({1'b0, r_hp_gain}));
            end
            swrm_pkg::ST_HA1: begin
                w_op.clear = 1'b0;
                w_op.neg   = 1'b1;
                w_op.a     = swrm_pkg::t_mul_a'(w_taps.y1);
                w_op.b     = swrm_pkg::t_mul_b'(signed'(r_hp_fb[swrm_pkg::COEF_W-1:0]));
            end
            swrm_pkg::ST_HA2: begin
                w_op.clear = 1'b0;
                w_op.neg   = 1'b1;
                w_op.a     = swrm_pkg::t_mul_a'(w_taps.y2);
                w_op.b     = swrm_pkg::t_mul_b'(
                    signed'(r_hp_fb[swrm_pkg::FB_W-1:swrm_pkg::COEF_W]));
            end
            swrm_pkg::ST_LC: begin
                w_op.a = swrm_pkg::t_mul_a'(w_lsum);
                w_op.b = swrm_pkg::t_mul_b'(signed'(r_cos));
            end
            swrm_pkg::ST_LS: begin
                w_op.clear = 1'b0;
                w_op.neg   = 1'b1;
                w_op.a     = swrm_pkg::t_mul_a'(w_rsum);
                w_op.b     = swrm_pkg::t_mul_b'(signed'(r_sin));
            end
            swrm_pkg::ST_RS: begin
                w_op.a = swrm_pkg::t_mul_a'(w_lsum);
                w_op.b = swrm_pkg::t_mul_b'(signed'(r_sin));
            end
            swrm_pkg::ST_RC: begin
                w_op.clear = 1'b0;
                w_op.a     = swrm_pkg::t_mul_a'(w_rsum);
                w_op.b     = swrm_pkg::t_mul_b'(signed'(r_cos));
            end
            swrm_pkg::ST_GL: begin
                w_op.a = swrm_pkg::t_mul_a'(r_lr);
                w_op.b = swrm_pkg::t_mul_b'(signed'({1'b0, r_lgain}));
            end
            swrm_pkg::ST_GR: begin
                w_op.clear = !w_mono;
                w_op.a     = swrm_pkg::t_mul_a'(r_rr);
                w_op.b     = swrm_pkg::t_mul_b'(signed'({1'b0, r_rgain}));
            end
            default: begin
                w_op.en = 1'b0;
            end
        endcase
    end

    swrm_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_op),
        .o_acc (w_acc)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mid  <= w_sum[swrm_pkg::IN_W:1];
            r_side <= swrm_pkg::t_side_s'(signed'(w_dif[swrm_pkg::IN_W:1]));
        end
        case (w_ctl.state)
            swrm_pkg::ST_SIDE: begin
                r_side <= swrm_pkg::t_side_s'(
                    signed'(w_acc[swrm_pkg::GAIN_FRAC +: swrm_pkg::WSIDE_W]));
            end
            swrm_pkg::ST_HSAT: r_side <= swrm_pkg::t_side_s'(w_y);
            swrm_pkg::ST_RS:   r_lr   <= w_rot;
            swrm_pkg::ST_GL:   r_rr   <= w_rot;
            swrm_pkg::ST_GR:   r_outl <= w_sat14;
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out_word.left_result  <= w_mono ? w_sat15 : r_outl;
            r_out_word.right_result <= w_mono ? w_sat15 : w_sat14;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `SWRM_ASSERT(a_accept_starts, i_clk, i_rst_n, w_accept |=> w_ctl.state == swrm_pkg::ST_WID)
    `SWRM_ASSERT(a_load_from_out, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(w_ctl.out_step))
    `SWRM_ASSERT(a_rot_stage_zero, i_clk, i_rst_n, w_ctl.state == swrm_pkg::ST_LC |-> !w_ctl.stage)
    `SWRM_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !w_ctl.out_step)

endmodule

[tb/sv/tb_stereo_width_rotation_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_width_rotation_mixer
// Self-checking bench for the stereo width / rotation mixer. A bit-exact
// predictor follows every accepted word, including the cascaded highpass
// delays, and each output word is checked field by field in order.
// Directed cases cover sample and register extremes, every mode flag and
// the held filter state in mono-bass mode; random phases then mix register
// settings with random samples under random idling and back pressure.
// ----------------------------------------------------------------------------
module tb_stereo_width_rotation_mixer;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 40;

    localparam int SAMPLE_BITS = swrm_pkg::SAMPLE_BITS;
    localparam int MODE_W      = swrm_pkg::MODE_W;
    localparam int CFG_W       = swrm_pkg::CFG_W;
    localparam int CFG_IDX_W   = swrm_pkg::CFG_IDX_W;
    localparam int WIDTH_W     = swrm_pkg::WIDTH_W;
    localparam int GAIN_W      = swrm_pkg::GAIN_W;
    localparam int TRIG_W      = swrm_pkg::TRIG_W;
    localparam int B0_W        = swrm_pkg::B0_W;
    localparam int FB_W        = swrm_pkg::FB_W;
    localparam int HP_W        = swrm_pkg::HP_W;
    localparam int COEF_W      = swrm_pkg::COEF_W;

    localparam logic [MODE_W-1:0] F_INV_L = MODE_W'(1 << swrm_pkg::MODE_INV_L);
    localparam logic [MODE_W-1:0] F_INV_R = MODE_W'(1 << swrm_pkg::MODE_INV_R);
    localparam logic [MODE_W-1:0] F_SWAP  = MODE_W'(1 << swrm_pkg::MODE_SWAP);
    localparam logic [MODE_W-1:0] F_MONO  = MODE_W'(1 << swrm_pkg::MODE_MONO);
    localparam logic [MODE_W-1:0] F_BASS  = MODE_W'(1 << swrm_pkg::MODE_BASS);

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = 24'sh800000;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    swrm_pkg::t_swrm_in   i_in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    swrm_pkg::t_swrm_out  o_out_word;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    // predictor copy of the registers and filter delays
    logic [MODE_W-1:0]        mode_r;
    logic [WIDTH_W-1:0]       width_r;
    logic [GAIN_W-1:0]        lgain_r;
    logic [GAIN_W-1:0]        rgain_r;
    logic [TRIG_W-1:0]        cos_r;
    logic [TRIG_W-1:0]        sin_r;
    logic [B0_W-1:0]          hpg_r;
    logic [FB_W-1:0]          hpfb_r;
    logic signed [HP_W-1:0]   hp_taps [8];

    swrm_pkg::t_swrm_out pending_pairs[$];
    swrm_pkg::t_swrm_out due_word;
    int        errors = 0;
    int        cycles = 0;
    bit        calm = 1'b0;

    stereo_width_rotation_mixer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint highpass_stage(input int base, input longint x,
                                              input longint b0, a1, a2);
        longint x1, x2, y1, y2, y;
        x1 = hp_taps[base];
        x2 = hp_taps[base + 1];
        y1 = hp_taps[base + 2];
        y2 = hp_taps[base + 3];
        y = clamp((b0 * (x - 2 * x1 + x2) - a1 * y1 - a2 * y2)
                  >>> swrm_pkg::COEF_FRAC_BITS, HP_W);
        hp_taps[base + 1] = hp_taps[base];
        hp_taps[base] = HP_W'(x);
        hp_taps[base + 3] = hp_taps[base + 2];
        hp_taps[base + 2] = HP_W'(y);
        return y;
    endfunction

    function automatic swrm_pkg::t_swrm_out mix_pair(input swrm_pkg::t_swrm_in w);
        longint l, r, t, mid, side, lr, rr, lo, ro;
        longint cs, sn, gl, gr;
        swrm_pkg::t_swrm_out res;
        l = $signed(w.left_sample);
        r = $signed(w.right_sample);
        cs = $signed(cos_r);
        sn = $signed(sin_r);
        gl = lgain_r;
        gr = rgain_r;
        if (mode_r[swrm_pkg::MODE_INV_L]) l = -l;
        if (mode_r[swrm_pkg::MODE_INV_R]) r = -r;
        if (mode_r[swrm_pkg::MODE_SWAP]) begin
            t = l;
            l = r;
            r = t;
        end
        mid = (l + r) >>> 1;
        side = (l - r) >>> 1;
        side = (side * longint'(width_r)) >>> swrm_pkg::GAIN_FRAC;
        if (mode_r[swrm_pkg::MODE_BASS]) begin
            side = clamp(side, HP_W);
            side = highpass_stage(0, side, hpg_r, $signed(hpfb_r[23:0]), $signed(hpfb_r[47:24]));
            side = highpass_stage(4, side, hpg_r, $signed(hpfb_r[23:0]), $signed(hpfb_r[47:24]));
        end
        l = mid + side;
        r = mid - side;
        lr = (l * cs - r * sn) >>> swrm_pkg::TRIG_FRAC;
        rr = (l * sn + r * cs) >>> swrm_pkg::TRIG_FRAC;
        if (mode_r[swrm_pkg::MODE_MONO]) begin
            lo = (lr * gl + rr * gr) >>> (swrm_pkg::GAIN_FRAC + 1);
            ro = lo;
        end else begin
            lo = (lr * gl) >>> swrm_pkg::GAIN_FRAC;
            ro = (rr * gr) >>> swrm_pkg::GAIN_FRAC;
        end
        res.left_result = SAMPLE_BITS'(clamp(lo, SAMPLE_BITS));
        res.right_result = SAMPLE_BITS'(clamp(ro, SAMPLE_BITS));
        return res;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(5))
            0: return SMIN;
            1: return SMAX;
            2: return SAMPLE_BITS'($urandom_range(511)) - SAMPLE_BITS'(256);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg(input longint lo, input longint hi,
                                                  input int bits);
        longint v;
        case ($urandom_range(4))
            0: v = lo;
            1: v = hi;
            2: v = lo + longint'($urandom_range(32'(hi - lo)));
            3: v = longint'($urandom) & ((longint'(1) <<< bits) - 1);
            default: v = (lo + hi) / 2;
        endcase
        return CFG_W'(v);
    endfunction

    // two poles just inside the unit circle, typical bass highpass
    function automatic logic [FB_W-1:0] stable_feedback();
        logic signed [COEF_W-1:0] a1, a2;
        a1 = -24'sd8215000 + COEF_W'($urandom_range(2000));
        a2 = 24'sd4027000 - COEF_W'($urandom_range(2000));
        return {a2, a1};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    task automatic reset_model();
        mode_r = swrm_pkg::RST_MODE;
        width_r = swrm_pkg::RST_WIDTH;
        lgain_r = swrm_pkg::RST_GAIN;
        rgain_r = swrm_pkg::RST_GAIN;
        cos_r = swrm_pkg::RST_COS;
        sin_r = swrm_pkg::RST_SIN;
        hpg_r = swrm_pkg::RST_HP_GAIN;
        hpfb_r = swrm_pkg::RST_HP_FB;
        for (int i = 0; i < 8; i++) hp_taps[i] = '0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            swrm_pkg::REG_MODE:    mode_r = val[MODE_W-1:0];
            swrm_pkg::REG_WIDTH:   width_r = val[WIDTH_W-1:0];
            swrm_pkg::REG_LGAIN:   lgain_r = val[GAIN_W-1:0];
            swrm_pkg::REG_RGAIN:   rgain_r = val[GAIN_W-1:0];
            swrm_pkg::REG_COS:     cos_r = val[TRIG_W-1:0];
            swrm_pkg::REG_SIN:     sin_r = val[TRIG_W-1:0];
            swrm_pkg::REG_HP_GAIN: hpg_r = val[B0_W-1:0];
            swrm_pkg::REG_HP_FB:   hpfb_r = val[FB_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
                             input logic signed [SAMPLE_BITS-1:0] r);
        while (!calm && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= '{left_sample: l, right_sample: r};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop sending and let the mixer drain before touching registers
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_random_config();
        write_reg(swrm_pkg::REG_MODE, CFG_W'($urandom_range(31)));
        write_reg(swrm_pkg::REG_WIDTH, pick_reg(0, 65536, WIDTH_W));
        write_reg(swrm_pkg::REG_LGAIN, pick_reg(0, 65536, GAIN_W));
        write_reg(swrm_pkg::REG_RGAIN, pick_reg(0, 65536, GAIN_W));
        write_reg(swrm_pkg::REG_COS, pick_reg(-65536, 65536, TRIG_W));
        write_reg(swrm_pkg::REG_SIN, pick_reg(-65536, 65536, TRIG_W));
        write_reg(swrm_pkg::REG_HP_GAIN, pick_reg(0, 4194304, B0_W));
        case ($urandom_range(2))
            0: write_reg(swrm_pkg::REG_HP_FB, '0);
            1: write_reg(swrm_pkg::REG_HP_FB, stable_feedback());
            default: write_reg(swrm_pkg::REG_HP_FB, {$urandom, $urandom});
        endcase
    endtask

    task automatic test_sample_extremes();
        send_pair('0, '0);
        send_pair(SMAX, SMAX);
        send_pair(SMIN, SMIN);
        send_pair(SMAX, SMIN);
        send_pair(SMIN, SMAX);
        send_pair(24'sd1, -24'sd1);
        send_pair(-24'sd1, -24'sd1);
    endtask

    task automatic test_mode_flags();
        settle();
        write_reg(swrm_pkg::REG_MODE, F_INV_L);
        send_pair(SMIN, 24'sd1000);
        settle();
        write_reg(swrm_pkg::REG_MODE, F_INV_R);
        send_pair(24'sd1000, SMIN);
        settle();
        write_reg(swrm_pkg::REG_MODE, F_SWAP);
        send_pair(SMAX, -24'sd4096);
        settle();
        write_reg(swrm_pkg::REG_MODE, F_MONO);
        send_pair(SMAX, 24'sd12345);
        settle();
        write_reg(swrm_pkg::REG_MODE, F_INV_L | F_INV_R | F_SWAP | F_MONO | F_BASS);
        send_pair(SMIN, SMAX);
    endtask

    // filter delays must survive a stretch with mono bass switched off
    task automatic test_bass_hold();
        settle();
        write_reg(swrm_pkg::REG_MODE, F_BASS);
        send_pair(24'sd300000, -24'sd200000);
        send_pair(-24'sd50000, 24'sd70000);
        send_pair(SMAX, SMIN);
        settle();
        write_reg(swrm_pkg::REG_MODE, '0);
        send_pair(24'sd1234, -24'sd4321);
        send_pair(SMIN, 24'sd99);
        settle();
        write_reg(swrm_pkg::REG_MODE, F_BASS);
        send_pair('0, '0);
        send_pair(24'sd77, -24'sd77);
    endtask

    task automatic test_register_edges();
        settle();
        write_reg(swrm_pkg::REG_MODE, F_BASS);
        write_reg(swrm_pkg::REG_WIDTH, CFG_W'(65536));
        write_reg(swrm_pkg::REG_LGAIN, CFG_W'(65536));
        write_reg(swrm_pkg::REG_RGAIN, CFG_W'(65536));
        write_reg(swrm_pkg::REG_COS, CFG_W'(-65536));
        write_reg(swrm_pkg::REG_SIN, CFG_W'(65536));
        write_reg(swrm_pkg::REG_HP_GAIN, CFG_W'(4194304));
        write_reg(swrm_pkg::REG_HP_FB, stable_feedback());
        send_pair(SMAX, SMIN);
        send_pair(SMIN, SMAX);
        settle();
        write_reg(swrm_pkg::REG_MODE, F_MONO);
        write_reg(swrm_pkg::REG_WIDTH, '0);
        write_reg(swrm_pkg::REG_LGAIN, '0);
        write_reg(swrm_pkg::REG_COS, '0);
        write_reg(swrm_pkg::REG_SIN, CFG_W'(-65536));
        write_reg(swrm_pkg::REG_HP_GAIN, '0);
        send_pair(SMAX, 24'sd4000);
        // bits beyond the stated ranges are taken as written
        settle();
        write_reg(swrm_pkg::REG_MODE, F_BASS | F_MONO);
        write_reg(swrm_pkg::REG_WIDTH, '1);
        write_reg(swrm_pkg::REG_LGAIN, '1);
        write_reg(swrm_pkg::REG_RGAIN, '1);
        write_reg(swrm_pkg::REG_COS, CFG_W'(-131072));
        write_reg(swrm_pkg::REG_SIN, CFG_W'(131071));
        write_reg(swrm_pkg::REG_HP_GAIN, '1);
        write_reg(swrm_pkg::REG_HP_FB, '1);
        send_pair(SMAX, SMIN);
        send_pair(24'sd5, SMAX);
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            settle();
            set_random_config();
            for (int k = 0; k < per_phase; k++) send_pair(rand_sample(), rand_sample());
        end
    endtask

    task automatic test_stable_highpass(input int count);
        settle();
        set_random_config();
        write_reg(swrm_pkg::REG_MODE, F_BASS | MODE_W'($urandom_range(15)));
        write_reg(swrm_pkg::REG_HP_GAIN, CFG_W'(4110000 + $urandom_range(2000)));
        write_reg(swrm_pkg::REG_HP_FB, stable_feedback());
        for (int k = 0; k < count; k++) send_pair(rand_sample(), rand_sample());
    endtask

    task automatic test_no_idle(input int count);
        settle();
        calm = 1'b1;
        set_random_config();
        for (int k = 0; k < count; k++) send_pair(rand_sample(), rand_sample());
        settle();
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 36);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pending_pairs.push_back(mix_pair(i_in_word));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pairs.size() == 0) begin
                report_mismatch("output word with nothing expected");
            end else begin
                due_word = pending_pairs.pop_front();
                if (o_out_word.left_result !== due_word.left_result) begin
                    report_mismatch($sformatf("left_result got %0d expected %0d",
                        o_out_word.left_result, due_word.left_result));
                end
                if (o_out_word.right_result !== due_word.right_result) begin
                    report_mismatch($sformatf("right_result got %0d expected %0d",
                        o_out_word.right_result, due_word.right_result));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                cycles, pending_pairs.size());
            $display("stereo_width_rotation_mixer regression: fail");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_sample_extremes();
        test_mode_flags();
        test_bass_hold();
        test_register_edges();
        test_random_phases(10, 80);
        test_stable_highpass(150);
        test_no_idle(150);
        settle();
        if (pending_pairs.size() != 0) begin
            report_mismatch($sformatf("%0d expected words never arrived", pending_pairs.size()));
        end
        if (errors == 0) begin
            $display("stereo_width_rotation_mixer regression: pass");
        end else begin
            $display("stereo_width_rotation_mixer regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/swrm_pkg.sv
hdl/swrm_mac.sv
hdl/swrm_hpd.sv
hdl/swrm_seq.sv
hdl/stereo_width_rotation_mixer.sv
tb/sv/tb_stereo_width_rotation_mixer.sv
